FILE: hdl/css_pkg.sv
// Shared types, codes and default sizes for the capped set of stacks.
package css_pkg;

    localparam int CSS_MAX_SUB_STACKS = 16;
    localparam int CSS_MAX_CAPACITY   = 64;
    localparam int CSS_VALUE_WIDTH    = 32;

    localparam int CSS_CAP_W          = 7;
    localparam logic [CSS_CAP_W-1:0] CSS_CAP_RESET = 7'd3;

    typedef enum logic [1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_TOP    = 2'd2,
        ACT_POP_AT = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_RANGE = 2'd2,
        ERR_FULL  = 2'd3
    } err_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] value;
        logic [3:0]         position;
    } css_in_t;

    typedef struct packed {
        logic signed [31:0] data;
        logic [1:0]         error;
        logic [4:0]         sub_stack_count;
    } css_out_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } css_cmd_t;

endpackage

FILE: hdl/css_ctrl.sv
// Controller: beat handshakes and the two-step item sequence.
module css_ctrl import css_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output css_cmd_t cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_ready;
        s_ready        = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE: begin
                // take a new beat only once the held result is gone or leaving
                s_ready = aresetn && (!out_valid_reg || m_ready);
                if (s_valid && s_ready) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.execute    = 1'b1;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
        endcase
    end

    assign m_valid = out_valid_reg;

    a_exec_then_result: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EXEC |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("execute step did not present a result");

    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE)
        else $error("input ready outside idle");

endmodule

FILE: hdl/css_datapath.sv
// Datapath: sub-stack bookkeeping, element memory and result register.
module css_datapath import css_pkg::*; #(
    parameter int MAX_SUB_STACKS = CSS_MAX_SUB_STACKS,
    parameter int MAX_CAPACITY   = CSS_MAX_CAPACITY,
    parameter int VALUE_WIDTH    = CSS_VALUE_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  css_cmd_t             cmd,
    input  css_in_t              in_item,
    input  logic                 cfg_we,
    input  logic [CSS_CAP_W-1:0] cfg_wdata,
    output css_out_t             out_item
);

    localparam int SLOT_W = (MAX_SUB_STACKS > 1) ? $clog2(MAX_SUB_STACKS) : 1;
    localparam int FILL_W = $clog2(MAX_CAPACITY + 1);
    localparam int CNT_W  = $clog2(MAX_SUB_STACKS + 1);
    localparam int DEPTH  = MAX_SUB_STACKS * MAX_CAPACITY;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    css_in_t                item_reg;
    logic [CSS_CAP_W-1:0]   cap_reg;
    logic [FILL_W-1:0]      fill_reg  [MAX_SUB_STACKS];
    logic [SLOT_W-1:0]      order_reg [MAX_SUB_STACKS];
    logic [CNT_W-1:0]       count_reg;
    logic [MAX_SUB_STACKS-1:0] free_reg;
    logic [VALUE_WIDTH-1:0] mem [DEPTH];
    logic [VALUE_WIDTH-1:0] rd_reg;
    err_t                   err_reg;
    logic [CNT_W-1:0]       cnt_out_reg;
    logic                   use_rd_reg;

    logic [FILL_W-1:0]      eff_cap;
    logic [CNT_W-1:0]       newest;
    logic [SLOT_W-1:0]      sel_pos;
    logic [SLOT_W-1:0]      sel_slot;
    logic [FILL_W-1:0]      sel_fill;
    logic [SLOT_W-1:0]      low_free;
    logic                   any_free;
    logic [63:0]            val_ext;
    logic [63:0]            rd_ext;

    err_t                   err_next;
    logic [CNT_W-1:0]       cnt_out_next;
    logic                   use_rd_next;
    logic                   mem_we, mem_re;
    logic [ADDR_W-1:0]      mem_addr;
    logic                   fill_we;
    logic [SLOT_W-1:0]      fill_slot;
    logic [FILL_W-1:0]      fill_val;
    logic                   open_new, close_up;

    function automatic logic [ADDR_W-1:0] elem_addr(input logic [SLOT_W-1:0] s,
                                                    input logic [FILL_W-1:0] i);
        return ADDR_W'(ADDR_W'(s) * ADDR_W'(MAX_CAPACITY) + ADDR_W'(i));
    endfunction

    // clamp capacity into 1..MAX_CAPACITY
    always_comb begin
        if (cap_reg == '0)
            eff_cap = FILL_W'(1);
        else if (int'(cap_reg) > MAX_CAPACITY)
            eff_cap = FILL_W'(MAX_CAPACITY);
        else
            eff_cap = FILL_W'(cap_reg);
    end

    assign newest   = count_reg - CNT_W'(1);
    assign sel_pos  = (action_t'(item_reg.action) == ACT_POP_AT) ?
                      SLOT_W'(item_reg.position) : newest[SLOT_W-1:0];
    assign sel_slot = order_reg[sel_pos];
    assign sel_fill = fill_reg[sel_slot];
    assign any_free = |free_reg;
    assign val_ext  = {{32{item_reg.value[31]}}, item_reg.value};

    always_comb begin
        low_free = '0;
        for (int i = MAX_SUB_STACKS - 1; i >= 0; i--) begin
            if (free_reg[i]) low_free = SLOT_W'(i);
        end
    end

    always_comb begin
        err_next    = ERR_OK;
        use_rd_next = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = '0;
        fill_we     = 1'b0;
        fill_slot   = sel_slot;
        fill_val    = '0;
        open_new    = 1'b0;
        close_up    = 1'b0;
        unique case (action_t'(item_reg.action))
            ACT_PUSH: begin
                if (count_reg == '0 || sel_fill >= eff_cap) begin
                    if (int'(count_reg) >= MAX_SUB_STACKS || !any_free) begin
                        err_next = ERR_FULL;
                    end else begin
                        open_new  = 1'b1;
                        fill_slot = low_free;
                        mem_we    = 1'b1;
                        mem_addr  = elem_addr(low_free, '0);
                        fill_we   = 1'b1;
                        fill_val  = FILL_W'(1);
                    end
                end else begin
                    mem_we   = 1'b1;
                    mem_addr = elem_addr(sel_slot, sel_fill);
                    fill_we  = 1'b1;
                    fill_val = sel_fill + FILL_W'(1);
                end
            end
            ACT_TOP: begin
                if (count_reg == '0 || sel_fill == '0) begin
                    err_next = ERR_EMPTY;
                end else begin
                    mem_re      = 1'b1;
                    use_rd_next = 1'b1;
                    mem_addr    = elem_addr(sel_slot, sel_fill - FILL_W'(1));
                end
            end
            ACT_POP, ACT_POP_AT: begin
                if (count_reg == '0 && action_t'(item_reg.action) == ACT_POP) begin
                    err_next = ERR_EMPTY;
                end else if (action_t'(item_reg.action) == ACT_POP_AT &&
                             32'(item_reg.position) >= 32'(count_reg)) begin
                    err_next = ERR_RANGE;
                end else begin
                    if (sel_fill != '0) begin
                        mem_re      = 1'b1;
                        use_rd_next = 1'b1;
                        mem_addr    = elem_addr(sel_slot, sel_fill - FILL_W'(1));
                        fill_we     = 1'b1;
                        fill_val    = sel_fill - FILL_W'(1);
                    end
                    // drop the sub-stack once it runs empty
                    close_up = (sel_fill <= FILL_W'(1));
                end
            end
        endcase
        cnt_out_next = count_reg + (open_new ? CNT_W'(1) : '0) -
                       (close_up ? CNT_W'(1) : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg   <= CSS_CAP_RESET;
            count_reg <= '0;
            free_reg  <= '1;
            for (int i = 0; i < MAX_SUB_STACKS; i++) fill_reg[i] <= '0;
        end else begin
            if (cfg_we) cap_reg <= cfg_wdata;
            if (cmd.execute) begin
                count_reg <= cnt_out_next;
                if (fill_we) fill_reg[fill_slot] <= fill_val;
                if (open_new) free_reg[low_free] <= 1'b0;
                if (close_up) free_reg[sel_slot] <= 1'b1;
            end
        end
    end

    // order list: append on open, close up from the removed position
    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            if (open_new) order_reg[count_reg[SLOT_W-1:0]] <= low_free;
            if (close_up) begin
                for (int i = 0; i < MAX_SUB_STACKS - 1; i++) begin
                    if (SLOT_W'(i) >= sel_pos && 32'(i + 1) < 32'(count_reg))
                        order_reg[i] <= order_reg[i + 1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) item_reg <= in_item;
        if (cmd.execute) begin
            err_reg     <= err_next;
            cnt_out_reg <= cnt_out_next;
            use_rd_reg  <= use_rd_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.execute && mem_we) mem[mem_addr] <= val_ext[VALUE_WIDTH-1:0];
        if (cmd.execute && mem_re) rd_reg <= mem[mem_addr];
    end

    assign rd_ext                   = 64'(rd_reg);
    assign out_item.data            = use_rd_reg ? rd_ext[31:0] : '0;
    assign out_item.error           = err_reg;
    assign out_item.sub_stack_count = 5'(cnt_out_reg);

    a_free_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(free_reg) + int'(count_reg) == MAX_SUB_STACKS)
        else $error("free mask and sub-stack count disagree");

    a_one_mem_access: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.execute |-> !(mem_we && mem_re))
        else $error("element memory read and written in one step");

endmodule

FILE: hdl/capped_set_of_stacks.sv
// Top level: capped set of stacks with push, pop, top and pop at position.
// An accepted beat is captured in the idle state, executed in the execute state, and its
//   result is then registered and presented. Each item takes a capture step and an execute
//   step on the single-port element memory; a new beat is taken as the previous result leaves.
// Reset (aresetn, synchronous, active low): no sub-stacks, all slots free,
//   capacity 3, input not ready; the element memory is not cleared.
module capped_set_of_stacks import css_pkg::*; #(
    parameter int MAX_SUB_STACKS = CSS_MAX_SUB_STACKS,
    parameter int MAX_CAPACITY   = CSS_MAX_CAPACITY,
    parameter int VALUE_WIDTH    = CSS_VALUE_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  css_in_t              s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output css_out_t             m_item,
    input  logic                 cfg_we,
    input  logic [CSS_CAP_W-1:0] cfg_wdata
);

    css_cmd_t cmd;

    // Controller: hold the input beat, run one execute step, present the result.
    css_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Datapath: fill counts, slot order, free mask, element memory, result.
    css_datapath #(
        .MAX_SUB_STACKS (MAX_SUB_STACKS),
        .MAX_CAPACITY   (MAX_CAPACITY),
        .VALUE_WIDTH    (VALUE_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .in_item   (s_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_item  (m_item)
    );

endmodule
